// ----- sv/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} item_t;

	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t init_h(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- sv/sha256_fifo.sv -----
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Four-entry queue between the intake side and the hashing engine.
// ----------------------------------------------------------------------------
module sha256_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  sha256_pkg::item_t   wr_item,
	output logic                rd_valid,
	input  logic                rd_ready,
	output sha256_pkg::item_t   rd_item
);
	sha256_pkg::item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_item  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

// ----- sv/sha256_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hashing engine
// Absorbs queued items into the block buffer, pads, compresses one round a
// cycle and streams the digest words out through a result register.
// ----------------------------------------------------------------------------
module sha256_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha256_pkg::item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_word,
	output logic [2:0]          out_index,
	output logic                out_last
);
	typedef enum logic [2:0] {
		ST_TAKE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
	} state_t;

	state_t      state_q;
	logic [31:0] buf_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [6:0]  fill_q;
	logic [60:0] count_q;
	logic [5:0]  round_q;
	logic [3:0]  load_q;
	logic        fin_q;
	logic        pad_q;
	logic        ext_q;
	logic        final_blk_q;
	logic [2:0]  oidx_q;

	logic [31:0] w_cur, t1, t2, s0, s1, x15, x2, e, a, buf_word;
	logic [63:0] bits;
	logic [4:0]  lane_lsb;

	assign in_ready = (state_q == ST_TAKE);
	assign bits = {count_q, 3'b000};
	// byte 0 of a word is its most significant lane
	assign lane_lsb = {~fill_q[1:0], 3'b000};
	assign buf_word = buf_q[load_q];

	always_comb begin
		x15 = w_q[4'(round_q + 6'd1)];
		x2  = w_q[4'(round_q + 6'd14)];
		s0  = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
		s1  = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
		w_cur = (round_q < 6'd16) ? w_q[round_q[3:0]]
			: w_q[round_q[3:0]] + s0 + w_q[4'(round_q + 6'd9)] + s1;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
			^ sha256_pkg::rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
			+ sha256_pkg::round_k(round_q) + w_cur;
		t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			fill_q      <= '0;
			count_q     <= '0;
			round_q     <= '0;
			load_q      <= '0;
			fin_q       <= 1'b0;
			pad_q       <= 1'b0;
			ext_q       <= 1'b0;
			final_blk_q <= 1'b0;
			oidx_q      <= '0;
			out_valid   <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
		end else begin
			unique case (state_q)
				ST_TAKE: begin
					if (in_valid) begin
						fin_q <= in_item.last;
						if (in_item.present) begin
							buf_q[fill_q[5:2]][lane_lsb +: 8] <= in_item.data;
							count_q <= count_q + 61'd1;
							if (fill_q == 7'd63) begin
								fill_q <= '0;
								final_blk_q <= 1'b0;
								load_q <= '0;
								state_q <= ST_LOAD;
							end else begin
								fill_q <= fill_q + 7'd1;
								if (in_item.last) state_q <= ST_PAD;
							end
						end else if (in_item.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// lay padding one byte a cycle; length goes in the last eight
					fin_q <= 1'b0;
					if (fin_q) begin
						buf_q[fill_q[5:2]][lane_lsb +: 8] <= sha256_pkg::PadByte;
						fill_q <= fill_q + 7'd1;
						pad_q <= 1'b1;
						// no room left for the length: zero this block, add another
						ext_q <= (fill_q >= 7'd56) && (fill_q != 7'd63);
						if (fill_q == 7'd63) begin
							fill_q <= '0;
							final_blk_q <= 1'b0;
							fin_q <= 1'b0;
							load_q <= '0;
							state_q <= ST_LOAD;
						end
					end else if (ext_q) begin
						buf_q[fill_q[5:2]][lane_lsb +: 8] <= 8'h00;
						if (fill_q == 7'd63) begin
							fill_q <= '0;
							ext_q <= 1'b0;
							final_blk_q <= 1'b0;
							load_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							fill_q <= fill_q + 7'd1;
						end
					end else if (fill_q < 7'd56) begin
						buf_q[fill_q[5:2]][lane_lsb +: 8] <= 8'h00;
						fill_q <= fill_q + 7'd1;
					end else begin
						buf_q[fill_q[5:2]][lane_lsb +: 8] <=
							8'(bits >> (7'd8 * (7'd63 - fill_q)));
						if (fill_q == 7'd63) begin
							fill_q <= '0;
							pad_q <= 1'b0;
							final_blk_q <= 1'b1;
							load_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							fill_q <= fill_q + 7'd1;
						end
					end
				end
				ST_LOAD: begin
					w_q[load_q] <= buf_word;
					if (load_q == 4'd15) begin
						round_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						state_q <= ST_ROUND;
					end
					load_q <= load_q + 4'd1;
				end
				ST_ROUND: begin
					w_q[round_q[3:0]] <= w_cur;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (final_blk_q) begin
						oidx_q <= '0;
						state_q <= ST_EMIT;
					end else if (fin_q || pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_TAKE;
					end
				end
				ST_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_word  <= h_q[oidx_q];
						out_index <= oidx_q;
						out_last  <= (oidx_q == 3'd7);
						oidx_q    <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
							count_q <= '0;
							fill_q  <= '0;
							state_q <= ST_TAKE;
						end
					end
				end
				default: state_q <= ST_TAKE;
			endcase
			if (state_q != ST_EMIT && out_valid && out_ready) out_valid <= 1'b0;
		end
	end
endmodule

// ----- sv/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// Input channel: one transaction per byte (byte_present) with an optional
// end_of_message flag; an empty end marker finishes without a byte.
// Output channel: eight transactions per message, digest_word in big-endian
// order, word_index 0..7, last_word on the eighth.
// Intake: each byte is absorbed on its own; every 64th byte starts a block
// compression (word load, rounds, fold) that stalls intake, so the sustained
// rate is set by the single round unit.
// End of message: padding fills the rest of the block one byte a cycle
// (up to two blocks); words leave the result reg one a cycle when out_ready.
// A four-entry queue takes bytes while a block compresses.
// Reset: clears the queue, restores the initial hash values and counts.
// A stalled receiver holds the result register and the engine waits.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	sha256_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;

	// pack the transaction fields for the queue
	assign in_item.data    = msg_byte;
	assign in_item.present = byte_present;
	assign in_item.last    = end_of_message;

	sha256_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	sha256_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(digest_word), .out_index(word_index), .out_last(last_word)
	);
endmodule

// ----- sv/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for digest ordering and handshake rules.
// ----------------------------------------------------------------------------
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word disagrees with word_index");
	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) ##1 out_valid
		|-> word_index == $past(word_index) + 3'd1)
		else $error("digest word out of order");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher sha256_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams with end markers through the valid/ready input, predicts
// each digest with an independent SHA-256 model and checks every output word.
// ----------------------------------------------------------------------------
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  msg_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	// Idling modes for the two sides of the run.
	typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

	sha256_stream_hasher uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.msg_byte(msg_byte), .byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Predictor state: chaining words, block bytes and message length.
	logic [31:0] chain_h[8];
	logic [7:0]  blk[64];
	int          blk_fill;
	logic [60:0] msg_len;

	sha256_pkg::item_t pending_items[$];
	digest_beat_t      expected_digests[$];
	int                mismatches = 0;
	idle_mode_t        idle_mode;
	bit                receiver_held;
	event              start_hold_off;

	localparam logic [31:0] IV[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KC[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run the 64 rounds over the current block and fold into the chain.
	task automatic compress_blk();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int r = 0; r < 64; r++) begin
			if (r < 16)
				w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
			else
				w[r] = w[r-16] + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
					+ w[r-7] + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
		end
		{a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
			chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + KC[r] + w[r];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endtask

	task automatic hasher_reset();
		chain_h = IV;
		blk_fill = 0;
		msg_len = '0;
	endtask

	// Absorb one accepted transaction; on end of message, pad and queue the digest.
	task automatic predict_digest(sha256_pkg::item_t it);
		logic [63:0] bits;
		digest_beat_t beat;
		if (it.present) begin
			blk[blk_fill] = it.data;
			blk_fill++;
			msg_len++;
			if (blk_fill == 64) begin
				compress_blk();
				blk_fill = 0;
			end
		end
		if (!it.last)
			return;
		bits = {msg_len, 3'b000};
		blk[blk_fill] = sha256_pkg::PadByte;
		blk_fill++;
		if (blk_fill > 56) begin
			for (int i = blk_fill; i < 64; i++) blk[i] = 8'h00;
			compress_blk();
			blk_fill = 0;
		end
		for (int i = blk_fill; i < 56; i++) blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
		compress_blk();
		for (int i = 0; i < 8; i++) begin
			beat.word = chain_h[i];
			beat.idx = 3'(i);
			beat.last = (i == 7);
			expected_digests.push_back(beat);
		end
		hasher_reset();
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic bit idle_now(bit receiver);
		case (idle_mode)
			IdleSender: return !receiver && $urandom_range(99, 0) < 76;
			IdleReceiver: return receiver && $urandom_range(99, 0) < 76;
			IdleBoth: return $urandom_range(99, 0) < 6;
			default: return 1'b0;
		endcase
	endfunction

	// Driver: hold valid and payload until the transaction is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			msg_byte <= '0;
			byte_present <= 1'b0;
			end_of_message <= 1'b0;
			hasher_reset();
		end else begin
			sha256_pkg::item_t it;
			if (in_valid && in_ready) begin
				predict_digest(sha256_pkg::item_t'({msg_byte, byte_present, end_of_message}));
			end
			if ((!in_valid || in_ready) && pending_items.size() > 0 && !idle_now(1'b0)) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				msg_byte <= it.data;
				byte_present <= it.present;
				end_of_message <= it.last;
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Hold the receiver off for a long stretch when asked.
	always begin
		@(start_hold_off);
		receiver_held <= 1'b1;
		repeat (400) @(posedge clk);
		receiver_held <= 1'b0;
	end

	// Monitor: compare each output transaction against the oldest expected word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_digests.size() == 0) begin
					report_mismatch("unexpected word", digest_word, '0);
				end else begin
					digest_beat_t e;
					e = expected_digests.pop_front();
					if (digest_word !== e.word) report_mismatch("digest_word", digest_word, e.word);
					if (word_index !== e.idx)
						report_mismatch("word_index", 32'(word_index), 32'(e.idx));
					if (last_word !== e.last)
						report_mismatch("last_word", 32'(last_word), 32'(e.last));
				end
			end
			if (receiver_held) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idle_now(1'b1);
			end
		end
	end

	task automatic queue_item(logic [7:0] d, logic p, logic l);
		pending_items.push_back(sha256_pkg::item_t'({d, p, l}));
	endtask

	task automatic queue_message(int len, int pattern);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9, 0) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
			case (pattern)
				0: queue_item(8'h00, 1'b1, 1'b0);
				1: queue_item(8'hff, 1'b1, 1'b0);
				default: queue_item(8'($urandom), 1'b1, 1'b0);
			endcase
		end
		// End either on the last byte or with an empty marker.
		if (len > 0 && $urandom_range(1, 0)) begin
			pending_items[$].last = 1'b1;
		end else begin
			queue_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_digests.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		idle_mode = IdleNone;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, idle items, byte with end, extreme bytes.
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'hff, 1'b0, 1'b0);
		queue_item(8'h61, 1'b1, 1'b0);
		queue_item(8'h62, 1'b1, 1'b0);
		queue_item(8'h63, 1'b1, 1'b1);
		queue_item(8'hff, 1'b1, 1'b1);
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'h55, 1'b0, 1'b1);
		wait_drained();

		// Padding boundaries: 55, 56, 63 and 64 byte messages, extreme contents.
		for (int ph = 0; ph < 4; ph++) begin
			idle_mode = idle_mode_t'(ph);
			queue_message((ph < 2) ? 55 + ph : 61 + ph, ph % 3);
			if (ph == 2) begin
				// Long receiver hold-off while input keeps flowing.
				queue_message(3, 2);
				queue_message(1, 2);
				-> start_hold_off;
			end
			queue_message($urandom_range(16, 0), 2);
			wait_drained();
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS sha256_stream_hasher");
		end else begin
			$display("FAIL sha256_stream_hasher");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL sha256_stream_hasher");
		$finish;
	end
endmodule
